// ===== rtl/core/bls_pkg.sv =====
package bls_pkg;

    // coordinate width; coordinates wrap at this width
    localparam int COORD_BITS = 16;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int ERR_BITS   = COORD_BITS + 3;
    localparam int LEFT_BITS  = COORD_BITS + 1;
    localparam int WIN_BITS   = 15;
    localparam int CMP_BITS   = ((COORD_BITS > WIN_BITS) ? COORD_BITS : WIN_BITS) + 1;
    localparam int COLOR_BITS = 32;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [WIN_BITS-1:0] WIN_WIDTH_RESET  = WIN_BITS'(1920);
    localparam logic [WIN_BITS-1:0] WIN_HEIGHT_RESET = WIN_BITS'(1080);

    localparam logic [CFG_IDX_BITS-1:0] REG_WIN_WIDTH  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_WIN_HEIGHT = CFG_IDX_BITS'(1);

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    typedef struct packed {
        logic                  func;
        logic [COORD_BITS-1:0] start_x;
        logic [COORD_BITS-1:0] start_y;
        logic [COORD_BITS-1:0] end_x;
        logic [COORD_BITS-1:0] end_y;
        logic [COLOR_BITS-1:0] line_color;
    } in_word_t;

    typedef struct packed {
        logic                  pixel_valid;
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic [COLOR_BITS-1:0] pixel_color;
        logic                  line_last;
    } pix_word_t;

    typedef struct packed {
        logic                    we;
        logic [CFG_IDX_BITS-1:0] index;
        logic [WIN_BITS-1:0]     data;
    } cfg_write_t;

endpackage

// ===== rtl/core/bls_in_stage.sv =====
module bls_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bls_pkg::in_word_t in_word,
    input  logic              advance,
    output logic              fire,
    output bls_pkg::in_word_t held_word
);
    import bls_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;
    logic     in_fire;

    // slot frees when its word moves on to the result register
    assign in_ready = !valid_reg || advance;
    assign in_fire  = in_valid && in_ready;
    assign fire     = valid_reg && advance;
    assign held_word = word_reg;

    always_comb
    begin
        if (in_fire)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            word_reg <= in_word;
        end
    end

endmodule

// ===== rtl/core/bls_core.sv =====
module bls_core (
    input  logic                clk,
    input  logic                rst_n,
    input  bls_pkg::cfg_write_t cfg,
    input  logic                fire,
    input  bls_pkg::in_word_t   word,
    output bls_pkg::pix_word_t  result
);
    import bls_pkg::*;

    logic [WIN_BITS-1:0]   win_width_reg;
    logic [WIN_BITS-1:0]   win_height_reg;

    logic [COORD_BITS-1:0] cur_x_reg,       cur_x_next;
    logic [COORD_BITS-1:0] cur_y_reg,       cur_y_next;
    logic [ERR_BITS-1:0]   err_reg,         err_next;
    logic [COORD_BITS-1:0] major_reg,       major_next;
    logic [COORD_BITS-1:0] minor_reg,       minor_next;
    logic [LEFT_BITS-1:0]  left_reg,        left_next;
    logic                  minor_neg_reg,   minor_neg_next;
    logic                  x_major_reg,     x_major_next;
    logic [COLOR_BITS-1:0] color_reg,       color_next;

    // load setup
    logic [DIFF_BITS-1:0]  dx;
    logic [DIFF_BITS-1:0]  dy;
    logic [DIFF_BITS-1:0]  dx_abs;
    logic [DIFF_BITS-1:0]  dy_abs;
    logic [COORD_BITS-1:0] adx;
    logic [COORD_BITS-1:0] ady;
    logic                  ld_x_major;
    logic                  ld_swap;
    logic                  ld_minor_neg;
    logic [COORD_BITS-1:0] ld_major;
    logic [COORD_BITS-1:0] ld_minor;

    // step
    logic                  bump;
    logic                  in_window;
    logic [COORD_BITS-1:0] minor_inc;
    logic [ERR_BITS-1:0]   minor2;
    logic [ERR_BITS-1:0]   major2;
    logic [ERR_BITS-1:0]   ld_minor2;
    logic [ERR_BITS-1:0]   ld_major_ext;
    logic [LEFT_BITS-1:0]  left_dec;

    assign dx = {word.end_x[COORD_BITS-1], word.end_x}
              - {word.start_x[COORD_BITS-1], word.start_x};
    assign dy = {word.end_y[COORD_BITS-1], word.end_y}
              - {word.start_y[COORD_BITS-1], word.start_y};
    assign dx_abs = dx[DIFF_BITS-1] ? (~dx + DIFF_BITS'(1)) : dx;
    assign dy_abs = dy[DIFF_BITS-1] ? (~dy + DIFF_BITS'(1)) : dy;
    assign adx = dx_abs[COORD_BITS-1:0];
    assign ady = dy_abs[COORD_BITS-1:0];

    // equal absolute deltas (equal endpoints included) fall to y major
    assign ld_x_major = ady < adx;
    assign ld_swap    = ld_x_major ? dx[DIFF_BITS-1] : dy[DIFF_BITS-1];
    assign ld_major   = ld_x_major ? adx : ady;
    assign ld_minor   = ld_x_major ? ady : adx;

    // after reordering the minor step flips sign
    always_comb
    begin
        if (ld_x_major)
        begin
            ld_minor_neg = ld_swap ? (!dy[DIFF_BITS-1] && (dy != '0)) : dy[DIFF_BITS-1];
        end
        else
        begin
            ld_minor_neg = ld_swap ? (!dx[DIFF_BITS-1] && (dx != '0)) : dx[DIFF_BITS-1];
        end
    end

    assign ld_minor2    = {{(ERR_BITS-COORD_BITS-1){1'b0}}, ld_minor, 1'b0};
    assign ld_major_ext = {{(ERR_BITS-COORD_BITS){1'b0}}, ld_major};

    assign minor2 = {{(ERR_BITS-COORD_BITS-1){1'b0}}, minor_reg, 1'b0};
    assign major2 = {{(ERR_BITS-COORD_BITS-1){1'b0}}, major_reg, 1'b0};
    assign bump   = !err_reg[ERR_BITS-1] && (err_reg != '0);
    assign minor_inc = minor_neg_reg ? {COORD_BITS{1'b1}} : COORD_BITS'(1);
    assign left_dec  = left_reg - LEFT_BITS'(1);

    assign in_window = !cur_x_reg[COORD_BITS-1] && !cur_y_reg[COORD_BITS-1]
                    && (CMP_BITS'(cur_x_reg) < CMP_BITS'(win_width_reg))
                    && (CMP_BITS'(cur_y_reg) < CMP_BITS'(win_height_reg));

    always_comb
    begin
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        err_next       = err_reg;
        major_next     = major_reg;
        minor_next     = minor_reg;
        left_next      = left_reg;
        minor_neg_next = minor_neg_reg;
        x_major_next   = x_major_reg;
        color_next     = color_reg;
        result         = '0;
        result.pixel_color = color_reg;

        case (word.func)
            FUNC_LOAD:
            begin
                x_major_next   = ld_x_major;
                cur_x_next     = ld_swap ? word.end_x : word.start_x;
                cur_y_next     = ld_swap ? word.end_y : word.start_y;
                major_next     = ld_major;
                minor_next     = ld_minor;
                minor_neg_next = ld_minor_neg;
                err_next       = ld_minor2 - ld_major_ext;
                left_next      = LEFT_BITS'(ld_major) + LEFT_BITS'(1);
                color_next     = word.line_color;
                result.pixel_color = word.line_color;
            end
            FUNC_STEP:
            begin
                if (left_reg == '0)
                begin
                    result.line_last = 1'b1;
                end
                else
                begin
                    result.pixel_valid = in_window;
                    result.pixel_x     = cur_x_reg;
                    result.pixel_y     = cur_y_reg;
                    result.line_last   = (left_dec == '0);
                    left_next = left_dec;
                    err_next  = bump ? (err_reg + minor2 - major2) : (err_reg + minor2);
                    if (x_major_reg)
                    begin
                        cur_x_next = cur_x_reg + COORD_BITS'(1);
                        if (bump)
                        begin
                            cur_y_next = cur_y_reg + minor_inc;
                        end
                    end
                    else
                    begin
                        cur_y_next = cur_y_reg + COORD_BITS'(1);
                        if (bump)
                        begin
                            cur_x_next = cur_x_reg + minor_inc;
                        end
                    end
                end
            end
            default:
            begin
                result.line_last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_width_reg  <= WIN_WIDTH_RESET;
            win_height_reg <= WIN_HEIGHT_RESET;
        end
        else if (cfg.we)
        begin
            case (cfg.index)
                REG_WIN_WIDTH:  win_width_reg  <= cfg.data;
                REG_WIN_HEIGHT: win_height_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            err_reg       <= '0;
            major_reg     <= '0;
            minor_reg     <= '0;
            left_reg      <= '0;
            minor_neg_reg <= 1'b0;
            x_major_reg   <= 1'b0;
            color_reg     <= '0;
        end
        else if (fire)
        begin
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            err_reg       <= err_next;
            major_reg     <= major_next;
            minor_reg     <= minor_next;
            left_reg      <= left_next;
            minor_neg_reg <= minor_neg_next;
            x_major_reg   <= x_major_next;
            color_reg     <= color_next;
        end
    end

endmodule

// ===== rtl/core/bls_out_stage.sv =====
module bls_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  bls_pkg::pix_word_t result,
    output logic               advance,
    output logic               out_valid,
    input  logic               out_ready,
    output bls_pkg::pix_word_t out_word
);
    import bls_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    pix_word_t word_reg;

    assign advance   = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_comb
    begin
        if (fire)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            word_reg <= result;
        end
    end

endmodule

// ===== rtl/core/bresenham_line_stepper.sv =====
// bresenham line stepper
// input channel (in_valid/in_ready) carries one word per command: func selects
// load (endpoints and color) or step (emit one pixel of the current line)
// output channel (out_valid/out_ready) returns exactly one word per input word,
// in order: a load answers with zeros and the new color, a step answers with
// the pixel, its window flag and a last flag (last is also set when no line is
// active)
// window registers must be written via cfg_we/cfg_index/cfg_data only while
// idle, which the block does not enforce; index 0 is the width, index 1 the
// height, 15 bits each; the word is taken into an input register, then one
// add and compare of the stepper moves it into the result register; throughput
// is one word per cycle while out_ready is high, set by the single error-term
// update per step; the stepper state lives in registers that advance with each
// word; when the receiver stalls the result register holds, the input register
// takes one more word only if empty, and in_ready stays low until out_ready
// returns; reset empties both registers, clears the line state (no line active)
// and restores the window to 1920 by 1080
module bresenham_line_stepper (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  func,
    input  logic signed [bls_pkg::COORD_BITS-1:0] start_x,
    input  logic signed [bls_pkg::COORD_BITS-1:0] start_y,
    input  logic signed [bls_pkg::COORD_BITS-1:0] end_x,
    input  logic signed [bls_pkg::COORD_BITS-1:0] end_y,
    input  logic        [bls_pkg::COLOR_BITS-1:0] line_color,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  pixel_valid,
    output logic signed [bls_pkg::COORD_BITS-1:0] pixel_x,
    output logic signed [bls_pkg::COORD_BITS-1:0] pixel_y,
    output logic        [bls_pkg::COLOR_BITS-1:0] pixel_color,
    output logic                                  line_last,
    input  logic                                  cfg_we,
    input  logic      [bls_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic          [bls_pkg::WIN_BITS-1:0] cfg_data
);
    import bls_pkg::*;

    in_word_t   in_word;
    in_word_t   held_word;
    pix_word_t  result;
    pix_word_t  out_word;
    cfg_write_t cfg;
    logic       fire;
    logic       advance;

    // pack the command word
    assign in_word.func       = func;
    assign in_word.start_x    = start_x;
    assign in_word.start_y    = start_y;
    assign in_word.end_x      = end_x;
    assign in_word.end_y      = end_y;
    assign in_word.line_color = line_color;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    // input register
    bls_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .advance   (advance),
        .fire      (fire),
        .held_word (held_word)
    );

    // line state, setup and per-pixel step
    bls_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .fire   (fire),
        .word   (held_word),
        .result (result)
    );

    // result register
    bls_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .result    (result),
        .advance   (advance),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    // unpack the result word
    assign pixel_valid = out_word.pixel_valid;
    assign pixel_x     = out_word.pixel_x;
    assign pixel_y     = out_word.pixel_y;
    assign pixel_color = out_word.pixel_color;
    assign line_last   = out_word.line_last;

endmodule
